// File: design/unesc_pkg.sv
// Package: shared types, constants and entity tables for the XML text unescaper.
`timescale 1ns / 1ps

package unesc_pkg;

    // Configuration port geometry
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_MAX_TEXT_LENGTH = 1'b0;
    localparam logic [15:0] MAX_TEXT_LENGTH_RESET = 16'd1024;

    // Most result items one input byte can cause
    localparam int BURST_MAX = 5;
    localparam int BURST_CNT_W = 3;

    // Characters of interest
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_G = 8'h67;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_M = 8'h6D;
    localparam logic [7:0] CH_P = 8'h70;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // Entity candidates
    localparam logic [1:0] CAND_AMP_ONLY = 2'd0;
    localparam logic [1:0] CAND_LT = 2'd1;
    localparam logic [1:0] CAND_GT = 2'd2;
    localparam logic [1:0] CAND_AMP = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_ELEMENT = 3'd1;
    localparam logic [2:0] ST_NO_GT = 3'd2;
    localparam logic [2:0] ST_NO_CLOSE = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HEAD = 3'd1,
        PH_TEXT = 3'd2,
        PH_OVER = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status;
        logic       last;
    } out_item_t;

    typedef out_item_t [BURST_MAX-1:0] burst_t;

    typedef struct packed {
        phase_t      phase;
        logic        early_open_seen;
        logic [2:0]  match_position;
        logic [1:0]  match_candidates;
        logic [16:0] raw_count;
    } parse_state_t;

    typedef struct packed {
        burst_t                 items;
        logic [BURST_CNT_W-1:0] count;
    } burst_load_t;

    // Character k of the entity named by cand
    function automatic logic [7:0] ent_char(input logic [1:0] cand, input logic [2:0] k);
        logic [7:0] ch;
        ch = CH_NUL;
        if (k == 3'd0) begin
            ch = CH_AMP;
        end else begin
            case (cand)
                CAND_LT: begin
                    case (k)
                        3'd1: ch = CH_L;
                        3'd2: ch = CH_T;
                        3'd3: ch = CH_SEMI;
                        default: ch = CH_NUL;
                    endcase
                end
                CAND_GT: begin
                    case (k)
                        3'd1: ch = CH_G;
                        3'd2: ch = CH_T;
                        3'd3: ch = CH_SEMI;
                        default: ch = CH_NUL;
                    endcase
                end
                CAND_AMP: begin
                    case (k)
                        3'd1: ch = CH_A;
                        3'd2: ch = CH_M;
                        3'd3: ch = CH_P;
                        3'd4: ch = CH_SEMI;
                        default: ch = CH_NUL;
                    endcase
                end
                default: ch = CH_NUL;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [2:0] ent_len(input logic [1:0] cand);
        logic [2:0] len;
        case (cand)
            CAND_LT, CAND_GT: len = 3'd4;
            CAND_AMP: len = 3'd5;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] ent_value(input logic [1:0] cand);
        logic [7:0] v;
        case (cand)
            CAND_LT: v = CH_LT;
            CAND_GT: v = CH_GT;
            CAND_AMP: v = CH_AMP;
            default: v = CH_NUL;
        endcase
        return v;
    endfunction

    function automatic out_item_t mk_byte(input logic [7:0] b);
        out_item_t it;
        it = '0;
        it.out_byte = b;
        return it;
    endfunction

    function automatic out_item_t mk_status(input logic [2:0] st);
        out_item_t it;
        it = '0;
        it.is_status = 1'b1;
        it.status = st;
        it.last = 1'b1;
        return it;
    endfunction

endpackage

// File: design/unesc_decode.sv
// Decoder: next parser state and the result burst for one input byte.
`timescale 1ns / 1ps

module unesc_decode (
    input  unesc_pkg::parse_state_t state_cur,
    input  unesc_pkg::in_item_t     item_in,
    input  logic [15:0]             max_text_length,
    output unesc_pkg::parse_state_t state_next,
    output unesc_pkg::burst_load_t  burst_out
);
    import unesc_pkg::*;

    logic [7:0]  c;
    logic [16:0] raw_inc;
    logic [1:0]  cand_sel;
    logic        mismatch;
    logic        fresh;
    logic [2:0]  base;

    assign c = item_in.char_byte;
    assign raw_inc = state_cur.raw_count + 17'd1;

    // Pick the entity from the byte after '&'
    always_comb begin
        case (c)
            CH_L: cand_sel = CAND_LT;
            CH_G: cand_sel = CAND_GT;
            CH_A: cand_sel = CAND_AMP;
            default: cand_sel = CAND_AMP_ONLY;
        endcase
    end

    // Advance the parser and build the burst
    always_comb begin
        state_next = state_cur;
        burst_out = '0;
        mismatch = 1'b0;
        fresh = 1'b0;
        base = 3'd0;
        if (item_in.start_req) begin
            state_next.early_open_seen = 1'b0;
            state_next.match_position = 3'd0;
            state_next.match_candidates = CAND_AMP_ONLY;
            state_next.raw_count = '0;
            if (c != CH_LT) begin
                burst_out.items[0] = mk_status(ST_NOT_ELEMENT);
                burst_out.count = 3'd1;
                state_next.phase = PH_DONE;
            end else begin
                state_next.phase = PH_HEAD;
            end
        end else begin
            unique case (state_cur.phase)
                PH_HEAD: begin
                    if (c == CH_NUL) begin
                        burst_out.items[0] = mk_status(ST_NO_GT);
                        burst_out.count = 3'd1;
                        state_next.phase = PH_DONE;
                    end else if (c == CH_GT) begin
                        if (state_cur.early_open_seen) begin
                            burst_out.items[0] = mk_status(ST_OK);
                            burst_out.count = 3'd1;
                            state_next.phase = PH_DONE;
                        end else begin
                            state_next.phase = PH_TEXT;
                        end
                    end else if (c == CH_LT) begin
                        state_next.early_open_seen = 1'b1;
                    end
                end
                PH_TEXT: begin
                    if (c == CH_NUL) begin
                        // Drop held bytes
                        state_next.match_position = 3'd0;
                        state_next.match_candidates = CAND_AMP_ONLY;
                        burst_out.items[0] = mk_status(ST_NO_CLOSE);
                        burst_out.count = 3'd1;
                        state_next.phase = PH_DONE;
                    end else if (c == CH_LT) begin
                        // Release held bytes, then close with ok
                        for (int k = 0; k < BURST_MAX; k++) begin
                            if (3'(k) < state_cur.match_position) begin
                                burst_out.items[k] = mk_byte(
                                    ent_char(state_cur.match_candidates, 3'(k)));
                            end
                        end
                        burst_out.items[state_cur.match_position] = mk_status(ST_OK);
                        burst_out.count = state_cur.match_position + 3'd1;
                        state_next.match_position = 3'd0;
                        state_next.match_candidates = CAND_AMP_ONLY;
                        state_next.phase = PH_DONE;
                    end else begin
                        state_next.raw_count = raw_inc;
                        if (raw_inc > {1'b0, max_text_length}) begin
                            state_next.match_position = 3'd0;
                            state_next.match_candidates = CAND_AMP_ONLY;
                            state_next.phase = PH_OVER;
                        end else begin
                            // Entity matching
                            if (state_cur.match_position == 3'd0) begin
                                fresh = 1'b1;
                            end else if (state_cur.match_position == 3'd1) begin
                                if (cand_sel != CAND_AMP_ONLY) begin
                                    state_next.match_candidates = cand_sel;
                                    state_next.match_position = 3'd2;
                                end else begin
                                    mismatch = 1'b1;
                                end
                            end else if (state_cur.match_position
                                         < ent_len(state_cur.match_candidates)
                                         && ent_char(state_cur.match_candidates,
                                                     state_cur.match_position) == c) begin
                                if (state_cur.match_position + 3'd1
                                    == ent_len(state_cur.match_candidates)) begin
                                    burst_out.items[0] = mk_byte(
                                        ent_value(state_cur.match_candidates));
                                    burst_out.count = 3'd1;
                                    state_next.match_position = 3'd0;
                                    state_next.match_candidates = CAND_AMP_ONLY;
                                end else begin
                                    state_next.match_position =
                                        state_cur.match_position + 3'd1;
                                end
                            end else begin
                                mismatch = 1'b1;
                            end

                            // Release held bytes verbatim on a mismatch
                            if (mismatch) begin
                                fresh = 1'b1;
                                base = state_cur.match_position;
                                for (int k = 0; k < BURST_MAX; k++) begin
                                    if (3'(k) < state_cur.match_position) begin
                                        burst_out.items[k] = mk_byte(
                                            ent_char(state_cur.match_candidates, 3'(k)));
                                    end
                                end
                            end

                            // Check the current byte from scratch
                            if (fresh) begin
                                state_next.match_candidates = CAND_AMP_ONLY;
                                if (c == CH_AMP) begin
                                    state_next.match_position = 3'd1;
                                    burst_out.count = base;
                                end else begin
                                    state_next.match_position = 3'd0;
                                    burst_out.items[base] = mk_byte(c);
                                    burst_out.count = base + 3'd1;
                                end
                            end
                        end
                    end
                end
                PH_OVER: begin
                    if (c == CH_NUL) begin
                        burst_out.items[0] = mk_status(ST_NO_CLOSE);
                        burst_out.count = 3'd1;
                        state_next.phase = PH_DONE;
                    end else if (c == CH_LT) begin
                        burst_out.items[0] = mk_status(ST_TOO_LONG);
                        burst_out.count = 3'd1;
                        state_next.phase = PH_DONE;
                    end
                end
                PH_IDLE, PH_DONE: begin
                    state_next = state_cur;
                end
                default: begin
                    state_next = state_cur;
                end
            endcase
        end
    end

endmodule

// File: design/unesc_burst.sv
// Result buffer: holds one burst and drains it through the output register.
`timescale 1ns / 1ps

module unesc_burst (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  unesc_pkg::burst_load_t burst_in,
    output logic                   load_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output unesc_pkg::out_item_t   m_payload
);
    import unesc_pkg::*;

    burst_t                 items_reg;
    logic [BURST_CNT_W-1:0] cnt_reg;
    logic [BURST_CNT_W-1:0] cnt_next;
    logic [BURST_CNT_W-1:0] idx_reg;
    logic [BURST_CNT_W-1:0] idx_next;
    logic [BURST_CNT_W-1:0] idx_inc;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    out_item_t              out_reg;
    logic                   pending;
    logic                   take;

    // Move the next buffered item into the output register when it is free
    assign pending = (idx_reg != cnt_reg);
    assign take = pending && (!m_valid_reg || m_ready);
    assign idx_inc = idx_reg + 3'd1;
    assign load_ready = !pending || (take && idx_inc == cnt_reg);

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = burst_in.count;
            idx_next = '0;
        end else if (take) begin
            idx_next = idx_inc;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load) begin
            items_reg <= burst_in.items;
        end
        if (take) begin
            out_reg <= items_reg[idx_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_payload = out_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(BURST_MAX))
        else $error("burst count beyond buffer depth");

    a_idx_le_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= cnt_reg)
        else $error("drain index passed burst count");

    a_load_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!pending || (take && idx_inc == cnt_reg)))
        else $error("burst loaded over undelivered results");

endmodule

// File: design/xml_node_text_unescape.sv
// Top level: XML element text extractor with entity decoding and APB config.
// Path: results of an accepted transaction are registered in the burst buffer, then
// in the output register on m_; later results follow one a cycle while m_ready is high.
// Throughput: one input transaction per cycle while each causes at most one result
// and m_ready is high; more results stall input until the last enters the output register.
// Reset (aresetn, synchronous, active low): parser idle, buffers empty, limit 1024.
`timescale 1ns / 1ps

module xml_node_text_unescape (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  unesc_pkg::in_item_t             s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output unesc_pkg::out_item_t            m_payload,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [unesc_pkg::PADDR_W-1:0]   paddr,
    input  logic [unesc_pkg::PDATA_W-1:0]   pwdata,
    output logic [unesc_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import unesc_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    burst_load_t  burst;
    logic [15:0]  max_len_reg;
    logic         load_ready;
    logic         accept;
    logic         cfg_write;
    logic         reg_hit;

    // Configuration register
    assign pready = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_MAX_TEXT_LENGTH);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata = reg_hit ? {16'd0, max_len_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_TEXT_LENGTH_RESET;
        end else if (cfg_write) begin
            max_len_reg <= pwdata[15:0];
        end
    end

    // Input transaction handshake
    assign s_ready = load_ready;
    assign accept = s_valid && s_ready;

    unesc_decode u_decode (
        .state_cur       (state_reg),
        .item_in         (s_payload),
        .max_text_length (max_len_reg),
        .state_next      (state_next),
        .burst_out       (burst)
    );

    // Parser state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_IDLE, early_open_seen: 1'b0,
                           match_position: 3'd0, match_candidates: CAND_AMP_ONLY,
                           raw_count: 17'd0};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    unesc_burst u_burst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .burst_in   (burst),
        .load_ready (load_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

    a_hold_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.match_position <= 3'd4)
        else $error("held entity bytes exceed four");

    a_hold_has_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.match_position >= 3'd2 |-> state_reg.match_candidates != CAND_AMP_ONLY)
        else $error("entity match past '&' without a candidate");

    a_hold_only_text: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.match_position != 3'd0 |-> state_reg.phase == PH_TEXT)
        else $error("held entity bytes outside text phase");

endmodule

// File: tb/tb.sv
// Testbench for the XML element text extractor: directed table, random runs, scoreboard.
`timescale 1ns / 1ps

module tb;
    import unesc_pkg::*;

    localparam int CLK_NS = 8;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int ITEMS_PER_PHASE = 45;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * REG_MAX_TEXT_LENGTH);

    // One row of the directed part: input byte, start flag, and an optional typed status
    typedef struct packed {
        logic [7:0] char_byte;
        logic       start_req;
        logic       typed;
        logic [2:0] st;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_payload;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_payload;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Scoreboard and stimulus stores
    out_item_t  want_q[$];
    out_item_t  step_res[$];
    in_item_t   stim_q[$];
    dir_row_t   directed [27];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_off = 1'b0;

    // Parser state mirror
    phase_t      p_phase;
    logic        p_early;
    logic [2:0]  p_held;
    logic [1:0]  p_cand;
    logic [16:0] p_raw;
    logic [15:0] text_limit;

    xml_node_text_unescape u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_NS / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_NS * TIMEOUT_CYCLES);
        $display("%0t: timeout, %0d results still pending", $time, want_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic out_item_t text_item(input logic [7:0] b);
        out_item_t it;
        it = '0;
        it.out_byte = b;
        return it;
    endfunction

    function automatic out_item_t status_item(input logic [2:0] st);
        out_item_t it;
        it = '0;
        it.is_status = 1'b1;
        it.status = st;
        it.last = 1'b1;
        return it;
    endfunction

    function automatic string entity_spelling(input logic [1:0] cand);
        string s;
        case (cand)
            CAND_LT:  s = "&lt;";
            CAND_GT:  s = "&gt;";
            CAND_AMP: s = "&amp;";
            default:  s = "&";
        endcase
        return s;
    endfunction

    function automatic void finish_run(input logic [2:0] st);
        step_res.push_back(status_item(st));
        p_phase = PH_DONE;
    endfunction

    // Release the held entity prefix verbatim
    function automatic void emit_held();
        string s;
        s = entity_spelling(p_cand);
        for (int k = 0; k < p_held && k < s.len(); k++) begin
            step_res.push_back(text_item(s[k]));
        end
        p_held = 3'd0;
        p_cand = CAND_AMP_ONLY;
    endfunction

    function automatic void take_fresh(input logic [7:0] c);
        if (c == CH_AMP) begin
            p_held = 3'd1;
            p_cand = CAND_AMP_ONLY;
        end else begin
            step_res.push_back(text_item(c));
        end
    endfunction

    function automatic void decode_char(input logic [7:0] c);
        logic [1:0] pick;
        string      s;
        pick = CAND_AMP_ONLY;
        s = entity_spelling(p_cand);
        if (p_held == 3'd0) begin
            take_fresh(c);
            return;
        end
        if (p_held == 3'd1) begin
            if (c == CH_L) pick = CAND_LT;
            else if (c == CH_G) pick = CAND_GT;
            else if (c == CH_A) pick = CAND_AMP;
            if (pick != CAND_AMP_ONLY) begin
                p_cand = pick;
                p_held = 3'd2;
                return;
            end
        end else if (p_held < s.len() && s[p_held] == c) begin
            p_held = p_held + 3'd1;
            // complete entity: emit its decoded character
            if (p_held == s.len()) begin
                case (p_cand)
                    CAND_LT: step_res.push_back(text_item(CH_LT));
                    CAND_GT: step_res.push_back(text_item(CH_GT));
                    default: step_res.push_back(text_item(CH_AMP));
                endcase
                p_held = 3'd0;
                p_cand = CAND_AMP_ONLY;
            end
            return;
        end
        // mismatch: flush the prefix, then look at this byte again
        emit_held();
        take_fresh(c);
    endfunction

    function automatic void predict_text(input in_item_t it);
        logic [7:0] c;
        c = it.char_byte;
        step_res.delete();
        if (it.start_req) begin
            p_early = 1'b0;
            p_held = 3'd0;
            p_cand = CAND_AMP_ONLY;
            p_raw = '0;
            if (c != CH_LT) finish_run(ST_NOT_ELEMENT);
            else p_phase = PH_HEAD;
            return;
        end
        case (p_phase)
            PH_HEAD: begin
                if (c == CH_NUL) begin
                    finish_run(ST_NO_GT);
                end else if (c == CH_GT) begin
                    if (p_early) finish_run(ST_OK);
                    else p_phase = PH_TEXT;
                end else if (c == CH_LT) begin
                    p_early = 1'b1;
                end
            end
            PH_TEXT: begin
                if (c == CH_NUL) begin
                    p_held = 3'd0;
                    p_cand = CAND_AMP_ONLY;
                    finish_run(ST_NO_CLOSE);
                end else if (c == CH_LT) begin
                    emit_held();
                    finish_run(ST_OK);
                end else begin
                    p_raw = p_raw + 17'd1;
                    if (p_raw > {1'b0, text_limit}) begin
                        p_held = 3'd0;
                        p_cand = CAND_AMP_ONLY;
                        p_phase = PH_OVER;
                    end else begin
                        decode_char(c);
                    end
                end
            end
            PH_OVER: begin
                if (c == CH_NUL) finish_run(ST_NO_CLOSE);
                else if (c == CH_LT) finish_run(ST_TOO_LONG);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void add_char(input logic [7:0] c, input logic s);
        in_item_t it;
        it.char_byte = c;
        it.start_req = s;
        stim_q.push_back(it);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_LT || c == CH_AMP);
        return c;
    endfunction

    // Append one element: mostly well formed with random text, else broken or noise
    function automatic void build_element();
        int         kind;
        int         n;
        int         cut;
        logic [7:0] c;
        string      s;
        kind = $urandom_range(99);
        if (kind < 75) begin
            add_char(CH_LT, 1'b1);
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) begin
                do c = plain_char(); while (c == CH_GT);
                add_char(($urandom_range(9) == 0) ? CH_LT : c, 1'b0);
            end
            add_char(CH_GT, 1'b0);
            n = $urandom_range(0, 7);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(2))
                    0: s = "&lt;";
                    1: s = "&gt;";
                    default: s = "&amp;";
                endcase
                case ($urandom_range(9))
                    4, 5: cut = s.len();
                    6, 7: cut = $urandom_range(1, s.len() - 1);
                    default: cut = 0;
                endcase
                for (int j = 0; j < cut; j++) add_char(s[j], 1'b0);
                if (cut == 0) add_char(plain_char(), 1'b0);
            end
            // close normally, end the string, or leave the run for the next start
            n = $urandom_range(19);
            if (n < 16) add_char(CH_LT, 1'b0);
            else if (n < 19) add_char(CH_NUL, 1'b0);
        end else if (kind < 85) begin
            add_char(CH_LT, 1'b1);
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) begin
                do c = plain_char(); while (c == CH_GT);
                add_char(c, 1'b0);
            end
            add_char(CH_NUL, 1'b0);
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(4))
                    0: c = CH_NUL;
                    1: c = CH_LT;
                    2: c = CH_GT;
                    3: c = CH_AMP;
                    default: c = 8'($urandom_range(255));
                endcase
                add_char(c, $urandom_range(2) == 0);
            end
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // Offer one transaction, predict it on acceptance, queue its results
    task automatic send_char(input in_item_t it, input logic typed, input logic [2:0] st);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_text(it);
        if (typed) begin
            want_q.push_back(status_item(st));
        end else begin
            foreach (step_res[i]) want_q.push_back(step_res[i]);
        end
    endtask

    task automatic drain();
        while (want_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic check_limit_reg(input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= LIMIT_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {16'h0, value}) begin
            mismatches++;
            $display("%0t: max_text_length read expected %08h actual %08h",
                     $time, {16'h0, value}, prdata);
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_text_limit(input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= {16'h0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        text_limit = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        check_limit_reg(value);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                mismatches++;
                $display("%0t: expected nothing, actual byte=%02h is_status=%0b %s",
                         $time, m_payload.out_byte, m_payload.is_status,
                         $sformatf("status=%0d last=%0b", m_payload.status,
                                   m_payload.last));
            end else begin
                e = want_q.pop_front();
                if (m_payload.out_byte !== e.out_byte || m_payload.is_status !== e.is_status ||
                    m_payload.status !== e.status || m_payload.last !== e.last) begin
                    mismatches++;
                    $display("%0t: expected byte=%02h is_status=%0b status=%0d last=%0b,",
                             $time, e.out_byte, e.is_status, e.status, e.last);
                    $display("%0t: actual byte=%02h is_status=%0b status=%0d last=%0b",
                             $time, m_payload.out_byte, m_payload.is_status,
                             m_payload.status, m_payload.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        in_item_t   it;
        logic [15:0] lim;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        text_limit = MAX_TEXT_LENGTH_RESET;
        p_phase = PH_IDLE;
        p_early = 1'b0;
        p_held = 3'd0;
        p_cand = CAND_AMP_ONLY;
        p_raw = '0;

        // Runs against a limit of five raw bytes
        directed = '{
            {CH_NUL, 1'b0, 1'b0, ST_OK},            // ignored while idle
            {"X",    1'b1, 1'b1, ST_NOT_ELEMENT},
            {CH_LT,  1'b1, 1'b0, ST_OK},
            {CH_NUL, 1'b0, 1'b1, ST_NO_GT},
            {CH_LT,  1'b1, 1'b0, ST_OK},
            {CH_LT,  1'b0, 1'b0, ST_OK},            // open bracket inside the tag
            {CH_GT,  1'b0, 1'b1, ST_OK},            // empty text
            {CH_LT,  1'b1, 1'b0, ST_OK},
            {CH_GT,  1'b0, 1'b0, ST_OK},
            {CH_AMP, 1'b0, 1'b0, ST_OK},
            {CH_A,   1'b0, 1'b0, ST_OK},
            {CH_M,   1'b0, 1'b0, ST_OK},
            {CH_P,   1'b0, 1'b0, ST_OK},
            {8'hFF,  1'b0, 1'b0, ST_OK},            // flushes four held bytes plus itself
            {"y",    1'b0, 1'b0, ST_OK},            // sixth raw byte: over the limit
            {CH_LT,  1'b0, 1'b1, ST_TOO_LONG},
            {CH_LT,  1'b1, 1'b0, ST_OK},
            {CH_GT,  1'b0, 1'b0, ST_OK},
            {CH_AMP, 1'b0, 1'b0, ST_OK},
            {CH_LT,  1'b0, 1'b0, ST_OK},            // close while a byte is held
            {CH_LT,  1'b1, 1'b0, ST_OK},
            {CH_GT,  1'b0, 1'b0, ST_OK},
            {CH_AMP, 1'b0, 1'b0, ST_OK},
            {CH_L,   1'b0, 1'b0, ST_OK},
            {CH_LT,  1'b1, 1'b0, ST_OK},            // restart abandons the run
            {CH_GT,  1'b0, 1'b0, ST_OK},
            {CH_NUL, 1'b0, 1'b1, ST_NO_CLOSE}       // string ends inside the text
        };

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        check_limit_reg(MAX_TEXT_LENGTH_RESET);
        set_text_limit(16'd5);

        foreach (directed[i]) begin
            it.char_byte = directed[i].char_byte;
            it.start_req = directed[i].start_req;
            send_char(it, directed[i].typed, directed[i].st);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        drain();

        // Random phases with different idle patterns and limits
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    lim = 16'hFFFF;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                    lim = 16'd0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                    lim = 16'($urandom_range(3, 12));
                end
                default: begin
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                    lim = 16'($urandom_range(2, 10));
                end
            endcase
            set_text_limit(lim);
            // hold the result side while the sender keeps pushing
            if (ph == 0) hold_off = 1'b1;
            stim_q.delete();
            while (stim_q.size() < ITEMS_PER_PHASE) build_element();
            foreach (stim_q[i]) send_char(stim_q[i], 1'b0, ST_OK);
            @(negedge aclk);
            s_valid <= 1'b0;
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/unesc_pkg.sv
design/unesc_decode.sv
design/unesc_burst.sv
design/xml_node_text_unescape.sv
tb/tb.sv
